/* rtl/mhpq_pkg.sv */
// mhpq_pkg: shared constants, codes and types for the priority queue
// used by mhpq_cell and max_heap_priority_queue; depends on nothing
package mhpq_pkg;

   localparam int CAPACITY = 32;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   // request kinds
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;
   localparam logic [1:0] KIND_SORT   = 2'd3;

   // response status
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // per-cycle cell operation, broadcast along the chain
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_SHIFT  = 2'd2;
   localparam logic [OP_W-1:0] OP_ROTATE = 2'd3;

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

endpackage

/* rtl/mhpq_cell.sv */
// mhpq_cell: one slot of the sorted chain, holds one entry and trades it with
// its neighbors; depends on mhpq_pkg
module mhpq_cell import mhpq_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [OP_W-1:0]           op,
   input  logic signed [VALUE_W-1:0] new_value,
   input  entry_type                 left_entry,
   input  logic                      left_keep,
   input  entry_type                 right_entry,
   output entry_type                 entry,
   output logic                      keep
);

   logic                      valid_ff;
   logic                      valid_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // entry stays ahead of a new value that is not larger
   assign keep  = valid_ff && (value_ff >= new_value);
   assign entry = '{valid: valid_ff, value: value_ff};

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      unique case (op)
         OP_HOLD: begin
            valid_in = valid_ff;
            value_in = value_ff;
         end
         OP_INSERT: begin
            if (keep) begin
               valid_in = valid_ff;
               value_in = value_ff;
            end else if (left_keep) begin
               valid_in = 1'b1;
               value_in = new_value;
            end else begin
               valid_in = left_entry.valid;
               value_in = left_entry.value;
            end
         end
         OP_SHIFT: begin
            valid_in = right_entry.valid;
            value_in = right_entry.value;
         end
         OP_ROTATE: begin
            valid_in = left_entry.valid;
            value_in = left_entry.value;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* rtl/max_heap_priority_queue.sv */
// max_heap_priority_queue: bounded max-priority queue built as a chain of cells
// depends on mhpq_pkg and mhpq_cell
//
// usage
//  - a request transfers at a rising edge with start high and busy low:
//    req_kind selects insert, delete max, search or sorted dump,
//    req_item_value carries the value for insert and search
//  - every result is on the rsp_ ports for one cycle with rsp_strobe high;
//    rsp_last marks the final result of a request; the receiver cannot stall
//  - entries sit in a row of CAPACITY cells sorted largest first; insert and
//    delete max move the whole row at once, the result shows in the cycle
//    after the transfer; busy stays low so a new request may follow at once
//  - search and sorted dump rotate the ring of cells once around, watching
//    the tail cell: busy from the transfer until the rotation ends, sorted
//    values come out smallest first as the tail cell shows them, the search
//    result on the final rotation step
//  - an empty queue answers delete and dump at once with status empty, a
//    full queue drops the insert value with status full
//  - reset empties the queue (cell valid bits and count) and ends any scan
module max_heap_priority_queue import mhpq_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_kind,
   input  logic signed [VALUE_W-1:0] req_item_value,
   output logic                      rsp_strobe,
   output logic signed [VALUE_W-1:0] rsp_result_value,
   output logic                      rsp_found,
   output logic [1:0]                rsp_status,
   output logic                      rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                      state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]          step_ff, step_in;
   logic [1:0]                scan_kind_ff, scan_kind_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic                      hit_ff, hit_in;

   logic                      strobe_ff, strobe_in;
   logic signed [VALUE_W-1:0] result_ff, result_in;
   logic                      found_ff, found_in;
   logic [1:0]                status_ff, status_in;
   logic                      last_ff, last_in;

   logic [OP_W-1:0] op;
   logic            accept;
   logic            is_full;
   logic            is_empty;
   logic            last_step;
   entry_type       tail;

   entry_type cell_entry [CAPACITY];
   logic      cell_keep  [CAPACITY];

   // cell chain, closed into a ring for the scan rotation
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_keep;

      if (i == 0) begin : g_head
         assign left_entry = cell_entry[CAPACITY-1];
         assign left_keep  = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_keep  = cell_keep[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      mhpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .new_value   (req_item_value),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .keep        (cell_keep[i])
      );
   end

   assign busy      = (state_ff == ST_SCAN);
   assign accept    = start && !busy;
   assign is_full   = (count_ff == COUNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign tail      = cell_entry[CAPACITY-1];
   assign last_step = (step_ff == IDX_W'(CAPACITY - 1));

   always_comb begin
      op           = OP_HOLD;
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      scan_kind_in = scan_kind_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      strobe_in    = 1'b0;
      result_in    = '0;
      found_in     = 1'b0;
      status_in    = STATUS_OK;
      last_in      = 1'b0;

      if (state_ff == ST_SCAN) begin
         // tail cell shows original slots from the back, so smallest first
         op      = OP_ROTATE;
         step_in = step_ff + IDX_W'(1);
         hit_in  = hit_ff || (tail.valid && (tail.value == key_ff));
         if (scan_kind_ff == KIND_SORT) begin
            strobe_in = tail.valid;
            result_in = tail.value;
            last_in   = last_step;
         end else if (last_step) begin
            strobe_in = 1'b1;
            found_in  = hit_in;
            last_in   = 1'b1;
         end
         if (last_step) begin
            state_in = ST_IDLE;
         end
      end else if (accept) begin
         unique case (req_kind)
            KIND_INSERT: begin
               strobe_in = 1'b1;
               last_in   = 1'b1;
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  op       = OP_INSERT;
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            KIND_DELETE: begin
               strobe_in = 1'b1;
               last_in   = 1'b1;
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  op        = OP_SHIFT;
                  result_in = cell_entry[0].value;
                  count_in  = count_ff - COUNT_W'(1);
               end
            end
            KIND_SEARCH: begin
               state_in     = ST_SCAN;
               step_in      = '0;
               scan_kind_in = req_kind;
               key_in       = req_item_value;
               hit_in       = 1'b0;
            end
            KIND_SORT: begin
               if (is_empty) begin
                  strobe_in = 1'b1;
                  status_in = STATUS_EMPTY;
                  last_in   = 1'b1;
               end else begin
                  state_in     = ST_SCAN;
                  step_in      = '0;
                  scan_kind_in = req_kind;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      scan_kind_ff <= scan_kind_in;
      key_ff       <= key_in;
      hit_ff       <= hit_in;
      result_ff    <= result_in;
      found_ff     <= found_in;
      status_ff    <= status_in;
      last_ff      <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_result_value = result_ff;
   assign rsp_found        = found_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

   // occupancy never passes the number of cells
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // when idle the valid cells agree with the count at both ends of the row
   a_row_matches_count: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (cell_entry[0].valid == !is_empty) &&
                (cell_entry[CAPACITY-1].valid == is_full))
      else $error("cell valid bits disagree with entry count");

   // a scan ends with the final result of its request on the response ports
   a_scan_ends_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe && rsp_last)
      else $error("scan ended without a final transfer");

endmodule

/* test/mhpq_response_checker.sv */
// mhpq_response_checker: watches the request and response channels of the
// priority queue, predicts every response and compares; depends on mhpq_pkg
`timescale 1ns / 100ps

module mhpq_response_checker import mhpq_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [1:0]                req_kind,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  logic                      rsp_strobe,
   input  logic signed [VALUE_W-1:0] rsp_result_value,
   input  logic                      rsp_found,
   input  logic [1:0]                rsp_status,
   input  logic                      rsp_last,
   output int                        mismatches,
   output int                        pending
);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      found;
      logic [1:0]                status;
      logic                      last;
   } queue_answer_type;

   // queue contents kept sorted smallest first
   logic signed [VALUE_W-1:0] held_values[$];
   queue_answer_type          answers_due[$];
   int                        error_count = 0;

   function automatic queue_answer_type make_answer(input logic signed [VALUE_W-1:0] value,
                                                    input logic found,
                                                    input logic [1:0] status,
                                                    input logic last);
      queue_answer_type a;
      a.value  = value;
      a.found  = found;
      a.status = status;
      a.last   = last;
      return a;
   endfunction

   task automatic predict_request(input logic [1:0] kind,
                                  input logic signed [VALUE_W-1:0] value);
      int                        pos;
      logic                      hit;
      logic signed [VALUE_W-1:0] swap;
      case (kind)
         KIND_INSERT: begin
            if (held_values.size() >= CAPACITY) begin
               answers_due.push_back(make_answer('0, 1'b0, STATUS_FULL, 1'b1));
            end else begin
               held_values.push_back(value);
               pos = held_values.size() - 1;
               while (pos > 0 && held_values[pos-1] > held_values[pos]) begin
                  swap               = held_values[pos];
                  held_values[pos]   = held_values[pos-1];
                  held_values[pos-1] = swap;
                  pos--;
               end
               answers_due.push_back(make_answer('0, 1'b0, STATUS_OK, 1'b1));
            end
         end
         KIND_DELETE: begin
            if (held_values.size() == 0) begin
               answers_due.push_back(make_answer('0, 1'b0, STATUS_EMPTY, 1'b1));
            end else begin
               answers_due.push_back(make_answer(held_values[$], 1'b0, STATUS_OK, 1'b1));
               void'(held_values.pop_back());
            end
         end
         KIND_SEARCH: begin
            hit = 1'b0;
            foreach (held_values[i]) begin
               if (held_values[i] == value) hit = 1'b1;
            end
            answers_due.push_back(make_answer('0, hit, STATUS_OK, 1'b1));
         end
         default: begin
            if (held_values.size() == 0) begin
               answers_due.push_back(make_answer('0, 1'b0, STATUS_EMPTY, 1'b1));
            end else begin
               foreach (held_values[i]) begin
                  answers_due.push_back(make_answer(held_values[i], 1'b0, STATUS_OK,
                                                    i == held_values.size() - 1));
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      queue_answer_type want;
      if (reset) begin
         held_values.delete();
         answers_due.delete();
      end else begin
         if (start && !busy) predict_request(req_kind, req_item_value);
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t unexpected response: value=%0d found=%0b status=%0d last=%0b",
                           $realtime, rsp_result_value, rsp_found, rsp_status, rsp_last);
            end else begin
               want = answers_due.pop_front();
               if (rsp_result_value !== want.value || rsp_found !== want.found ||
                   rsp_status !== want.status || rsp_last !== want.last) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t response mismatch:", $realtime,
                              " expected value=%0d found=%0b status=%0d last=%0b,",
                              want.value, want.found, want.status, want.last,
                              " got value=%0d found=%0b status=%0d last=%0b",
                              rsp_result_value, rsp_found, rsp_status, rsp_last);
               end
            end
         end
      end
      mismatches <= error_count;
      pending    <= answers_due.size();
   end

endmodule

/* test/tb_max_heap_priority_queue.sv */
// tb_max_heap_priority_queue: stimulus and verdict for the priority queue
// depends on mhpq_pkg, max_heap_priority_queue and mhpq_response_checker
`timescale 1ns / 100ps

module tb_max_heap_priority_queue;
   import mhpq_pkg::*;

   localparam int ITEM_TOTAL  = 460;
   localparam int CALM_ITEMS  = 60;            // final stretch sent without gaps
   localparam int STALL_LIMIT = 2000;          // cycles with no transfer at all
   localparam int TAIL_CYCLES = CAPACITY + 8;  // a full scan plus margin

   // traffic mix of one random phase
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND, MIX_SCAN, MIX_PURE_FILL} mix_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_kind = KIND_INSERT;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic                      rsp_strobe;
   logic signed [VALUE_W-1:0] rsp_result_value;
   logic                      rsp_found;
   logic [1:0]                rsp_status;
   logic                      rsp_last;

   int mismatches;
   int pending;
   int issued = 0;
   int stall_cycles = 0;

   // values inserted lately, reused so searches hit
   logic signed [VALUE_W-1:0] recent_inserts[8];
   int                        recent_slot = 0;

   always #4 clock = ~clock;

   max_heap_priority_queue dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_item_value   (req_item_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   mhpq_response_checker rsp_monitor (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_item_value   (req_item_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   // watchdog: any request or response transfer restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // called just after a falling edge, returns just after the falling edge
   // that follows the transfer; start stays high for a following request
   task automatic send_request(input logic [1:0] kind,
                               input logic signed [VALUE_W-1:0] value);
      start          <= 1'b1;
      req_kind       <= kind;
      req_item_value <= value;
      // busy is settled at the falling edge, so it tells whether the
      // coming rising edge takes the transfer
      while (busy) @(negedge clock);
      @(negedge clock);
      issued++;
      if (kind == KIND_INSERT) begin
         recent_inserts[recent_slot] = value;
         recent_slot = (recent_slot + 1) % 8;
      end
   endtask

   task automatic idle_cycles(input int count);
      start <= 1'b0;
      repeat (count) @(negedge clock);
   endtask

   // most often a small pool so duplicates and search hits are common,
   // else the extremes, recent inserts and full-width noise
   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $signed($urandom_range(0, 15)) - 32'sd8;
         4: begin
            case ($urandom_range(0, 3))
               0:       v = 32'sh7FFF_FFFF;
               1:       v = $signed(32'h8000_0000);
               2:       v = '0;
               default: v = -32'sd1;
            endcase
         end
         5, 6:    v = recent_inserts[$urandom_range(0, 7)];
         default: v = $signed($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [1:0] pick_kind(input mix_type mix);
      int draw;
      int ins_cut;
      int del_cut;
      int srch_cut;
      case (mix)
         MIX_PURE_FILL: begin ins_cut = 100; del_cut = 100; srch_cut = 100; end
         MIX_FILL:      begin ins_cut = 85;  del_cut = 90;  srch_cut = 96;  end
         MIX_DRAIN:     begin ins_cut = 15;  del_cut = 80;  srch_cut = 92;  end
         MIX_BLEND:     begin ins_cut = 40;  del_cut = 70;  srch_cut = 88;  end
         default:       begin ins_cut = 20;  del_cut = 40;  srch_cut = 75;  end
      endcase
      draw = $urandom_range(0, 99);
      if (draw < ins_cut) return KIND_INSERT;
      if (draw < del_cut) return KIND_DELETE;
      if (draw < srch_cut) return KIND_SEARCH;
      return KIND_SORT;
   endfunction

   initial begin
      mix_type                   mix;
      int                        phase_len;
      logic [1:0]                kind;
      logic signed [VALUE_W-1:0] value;

      foreach (recent_inserts[i]) recent_inserts[i] = '0;

      // reset held from the start, released at a falling edge
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty queue answers
      send_request(KIND_DELETE, 32'sd5);
      send_request(KIND_SORT, -32'sd1);
      send_request(KIND_SEARCH, '0);
      // extremes and a duplicate, back to back
      send_request(KIND_INSERT, 32'sh7FFF_FFFF);
      send_request(KIND_INSERT, $signed(32'h8000_0000));
      send_request(KIND_INSERT, '0);
      send_request(KIND_INSERT, -32'sd1);
      send_request(KIND_INSERT, 32'sd1);
      send_request(KIND_INSERT, -32'sd1);
      // search hits and a miss
      send_request(KIND_SEARCH, $signed(32'h8000_0000));
      send_request(KIND_SEARCH, 32'sd2);
      send_request(KIND_SEARCH, -32'sd1);
      // sorted dump with the extremes at both ends
      send_request(KIND_SORT, '0);
      send_request(KIND_DELETE, '0);
      send_request(KIND_DELETE, $signed(32'hFFFF_FFFF));
      send_request(KIND_SEARCH, 32'sh7FFF_FFFF);
      // alternating bit patterns
      send_request(KIND_INSERT, 32'sh5555_5555);
      send_request(KIND_INSERT, $signed(32'hAAAA_AAAA));
      idle_cycles(3);
      send_request(KIND_SORT, 32'sh1234_5678);
      send_request(KIND_DELETE, '0);

      // random phases, the first one fills past capacity to hit full
      mix       = MIX_PURE_FILL;
      phase_len = CAPACITY + 6;
      while (issued < ITEM_TOTAL) begin
         for (int j = 0; j < phase_len && issued < ITEM_TOTAL; j++) begin
            kind  = pick_kind(mix);
            value = pick_value();
            send_request(kind, value);
            // gaps in bursts, none in the final stretch
            if (issued < ITEM_TOTAL - CALM_ITEMS && $urandom_range(0, 3) == 0)
               idle_cycles($urandom_range(1, 6));
         end
         mix       = mix_type'($urandom_range(0, 3));
         phase_len = $urandom_range(20, 60);
      end
      start <= 1'b0;

      // drain: the watchdog catches responses that never come
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
